// ===== rtl/spd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg - shared constants for the segment point distance unit
// Field widths, fixed-point scaling and configuration register indexes.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int FIELD_W    = 32;  // coordinate and start field width
  localparam int DIR_W      = 16;  // direction component width, Q2.14
  localparam int LEN_W      = 31;  // segment length width, unsigned Q15.16
  localparam int DIST_W     = 32;  // distance width, unsigned Q16.16
  localparam int ACC_W      = 2 * DIST_W;  // sum of squares, Q32.32
  localparam int DIR_FRAC   = 14;  // fraction bits of a direction component
  localparam int ROUND_HALF = 8192;  // one half in units of the Q.30 residual
  localparam int CFG_W      = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SEG_LEN = 3'd6;

  localparam logic signed [DIR_W-1:0] DIR_X_RESET = 16'sd16384;

endpackage

// ===== rtl/segment_point_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_point_distance_unit - distance from a 3D point to a line segment
// Fully pipelined projection, clamp, residual and square root, one request
// per clock while the output buffer has its spare entry free.
// ----------------------------------------------------------------------------
// The segment is programmed through the write port as a start point (signed
// Q16.16), a unit direction (signed Q2.14, used as written) and a length
// (unsigned Q15.16); program it only while no request is in flight. Each query
// request returns one result: the floor of the Euclidean distance in unsigned
// Q16.16, or all ones with saturated set when the distance does not fit. The
// unit accepts one request every clock while the spare output entry is free. A
// result passes through seven arithmetic stages (offset, projection products,
// projection sum and clamp, residual products, residual rounding, squares,
// sum of squares), then 32 stages of the square root, one result bit per
// stage, then the output register. A two-entry output buffer lets the pipeline
// keep moving while a result waits; the input stalls only when both entries
// are full.
// ----------------------------------------------------------------------------
module segment_point_distance_unit
  import spd_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // query request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIELD_W-1:0]   query_x,
  input  logic [FIELD_W-1:0]   query_y,
  input  logic [FIELD_W-1:0]   query_z,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIST_W-1:0]    distance,
  output logic                 saturated
);

  // Coordinates are taken as signed values of the low CW bits.
  localparam int CW        = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int D_W       = CW + 1;               // point minus start
  localparam int P_W       = D_W + DIR_W;          // projection product
  localparam int DOT_W     = P_W + 2;              // sum of three products
  localparam int TV_W      = LEN_W + 1 + DIR_W;    // t times direction, Q.30
  localparam int SQ_STAGES = DIST_W;               // one root bit per stage

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0]      start [3];
  logic signed [DIR_W-1:0] dir   [3];
  logic [LEN_W-1:0]        seg_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      start[0] <= '0;
      start[1] <= '0;
      start[2] <= '0;
      dir[0]   <= DIR_X_RESET;
      dir[1]   <= '0;
      dir[2]   <= '0;
      seg_len  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X: start[0] <= cfg_data[FIELD_W-1:0];
        REG_START_Y: start[1] <= cfg_data[FIELD_W-1:0];
        REG_START_Z: start[2] <= cfg_data[FIELD_W-1:0];
        REG_DIR_X:   dir[0]   <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:   dir[1]   <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:   dir[2]   <= cfg_data[DIR_W-1:0];
        REG_SEG_LEN: seg_len  <= cfg_data[LEN_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. Every stage moves on together whenever the output buffer
  // has its spare entry free, so valid bits and data never part company.
  // --------------------------------------------------------------------------
  logic adv;
  logic skid_vld;

  assign adv      = !skid_vld;
  assign in_ready = adv;

  logic [FIELD_W-1:0] qin [3];
  assign qin[0] = query_x;
  assign qin[1] = query_y;
  assign qin[2] = query_z;

  // Stage A: offset of the query from the segment start.
  logic              vld_a;
  logic signed [D_W-1:0] d_a [3];

  // Stage B: products of the offset with the direction.
  logic              vld_b;
  logic signed [D_W-1:0] d_b    [3];
  logic signed [P_W-1:0] prod_b [3];

  // Stage C: projection t, floored to Q15.16 and clamped to the segment.
  logic              vld_c;
  logic signed [D_W-1:0] d_c [3];
  logic [LEN_W-1:0]      t_c;

  // Stage D: t times each direction component, exact in Q.30.
  logic              vld_d;
  logic signed [D_W-1:0]  d_d  [3];
  logic signed [TV_W-1:0] tv_d [3];

  // Stage E: residual magnitudes rounded to Q16.16.
  logic              vld_e;
  logic [DIST_W-1:0] mag_e [3];
  logic              over_e;

  // Stage F: squares of the residual components.
  logic              vld_f;
  logic [ACC_W-1:0]  sq_f [3];
  logic              over_f;

  // Square root stages; entry 0 holds the sum of squares (stage G).
  logic [SQ_STAGES:0] sr_vld;
  logic [ACC_W-1:0]   sr_num [0:SQ_STAGES];
  logic [ACC_W-1:0]   sr_res [0:SQ_STAGES];
  logic               sr_sat [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a  <= 1'b0;
      vld_b  <= 1'b0;
      vld_c  <= 1'b0;
      vld_d  <= 1'b0;
      vld_e  <= 1'b0;
      vld_f  <= 1'b0;
      sr_vld <= '0;
    end else if (adv) begin
      vld_a  <= in_valid;
      vld_b  <= vld_a;
      vld_c  <= vld_b;
      vld_d  <= vld_c;
      vld_e  <= vld_d;
      vld_f  <= vld_e;
      sr_vld <= {sr_vld[SQ_STAGES-1:0], vld_f};
    end
  end

  // Combinational parts of stages C, E and G.
  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] t_full;
  logic signed [DOT_W-1:0] len_ext;
  logic [LEN_W-1:0]        t_next;
  logic signed [TV_W-1:0]  r_e   [3];
  logic [TV_W-1:0]         abs_e [3];
  logic [2:0]              over_c;
  logic [ACC_W+1:0]        acc;

  always_comb begin
    dot = DOT_W'(prod_b[0]) + DOT_W'(prod_b[1]) + DOT_W'(prod_b[2]);
    // an arithmetic shift floors toward minus infinity
    t_full  = dot >>> DIR_FRAC;
    len_ext = $signed({{(DOT_W-LEN_W){1'b0}}, seg_len});
    if (t_full[DOT_W-1]) begin
      t_next = '0;
    end else if (t_full > len_ext) begin
      t_next = seg_len;
    end else begin
      t_next = t_full[LEN_W-1:0];
    end

    // The offset term is a whole multiple of 2^14, so it comes out of the
    // rounding shift unchanged.
    for (int i = 0; i < 3; i++) begin
      r_e[i]    = ((tv_d[i] + TV_W'(ROUND_HALF)) >>> DIR_FRAC) - TV_W'(d_d[i]);
      abs_e[i]  = r_e[i][TV_W-1] ? TV_W'(-r_e[i]) : TV_W'(r_e[i]);
      over_c[i] = |abs_e[i][TV_W-1:DIST_W];
    end

    acc = (ACC_W+2)'(sq_f[0]) + (ACC_W+2)'(sq_f[1]) + (ACC_W+2)'(sq_f[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_a[i]    <= D_W'($signed(qin[i][CW-1:0])) - D_W'($signed(start[i][CW-1:0]));
        d_b[i]    <= d_a[i];
        prod_b[i] <= P_W'(d_a[i]) * P_W'(dir[i]);
        d_c[i]    <= d_b[i];
        d_d[i]    <= d_c[i];
        tv_d[i]   <= TV_W'($signed({1'b0, t_c})) * TV_W'(dir[i]);
        mag_e[i]  <= abs_e[i][DIST_W-1:0];
        sq_f[i]   <= ACC_W'(mag_e[i]) * ACC_W'(mag_e[i]);
      end
      t_c       <= t_next;
      over_e    <= |over_c;
      over_f    <= over_e;
      sr_num[0] <= acc[ACC_W-1:0];
      sr_res[0] <= '0;
      sr_sat[0] <= over_f | (|acc[ACC_W+1:ACC_W]);
    end
  end

  // --------------------------------------------------------------------------
  // Square root by digit recurrence: each stage tries one result bit against
  // the remaining radicand.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (ACC_W - 2 - 2 * k);
    logic [ACC_W-1:0] trial;
    logic             take;

    assign trial = sr_res[k] + BIT;
    assign take  = (sr_num[k] >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_num[k+1] <= take ? (sr_num[k] - trial) : sr_num[k];
        sr_res[k+1] <= take ? ((sr_res[k] >> 1) + BIT) : (sr_res[k] >> 1);
        sr_sat[k+1] <= sr_sat[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with one spare entry behind it.
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0] last_dist;
  logic              last_sat;
  logic              push;
  logic              pop;
  logic [DIST_W-1:0] skid_dist;
  logic              skid_sat;

  assign last_sat  = sr_sat[SQ_STAGES];
  assign last_dist = last_sat ? '1 : sr_res[SQ_STAGES][DIST_W-1:0];
  assign push      = adv && sr_vld[SQ_STAGES];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (pop) begin
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (pop) begin
        distance  <= skid_dist;
        saturated <= skid_sat;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        distance  <= last_dist;
        saturated <= last_sat;
      end else begin
        skid_dist <= last_dist;
        skid_sat  <= last_sat;
      end
    end
  end

endmodule

// ===== rtl/spd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_checker - port-level checks for the segment point distance unit
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module spd_checker
  import spd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] distance,
  input logic              saturated
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(saturated))
    else $error("result changed or vanished while stalled");

  // A saturated result always carries the all-ones distance.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> distance == {DIST_W{1'b1}})
    else $error("saturated result without all-ones distance");

  // The input only stalls once a result is already waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // Reset leaves no result on the port.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind segment_point_distance_unit spd_checker u_spd_checker (.*);

// ===== sim/spd_distance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_distance_checker - result checker for the segment point distance unit
// Tracks the segment geometry from the write port, predicts the distance for
// every accepted query request and compares each accepted result in order.
// ----------------------------------------------------------------------------
module spd_distance_checker
  import spd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [FIELD_W-1:0]   query_x,
  input  logic [FIELD_W-1:0]   query_y,
  input  logic [FIELD_W-1:0]   query_z,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [DIST_W-1:0]    distance,
  input  logic                 saturated,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   saturations
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } dist_result_t;

  logic signed [FIELD_W-1:0] seg_start [3];
  logic signed [DIR_W-1:0]   seg_dir   [3];
  logic        [LEN_W-1:0]   seg_len;

  dist_result_t expected_dist_q [$];

  // Floor of the square root, built one result bit at a time from the top.
  function automatic logic [DIST_W-1:0] floor_sqrt(input logic [ACC_W-1:0] radicand);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] trial;
    int b;
    root = '0;
    for (b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (DIST_W'(1) << b);
      if (ACC_W'(trial) * ACC_W'(trial) <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic dist_result_t predict_distance(input logic [FIELD_W-1:0] qx,
                                                    input logic [FIELD_W-1:0] qy,
                                                    input logic [FIELD_W-1:0] qz);
    logic [FIELD_W-1:0] q [3];
    longint            offs [3];
    longint            dirc [3];
    longint            proj;
    longint            resid;
    logic [63:0]       mag;
    logic [ACC_W-1:0]  sq;
    logic [ACC_W+1:0]  sum_sq;
    logic              over;
    dist_result_t      res;
    int                c;
    q[0]   = qx;
    q[1]   = qy;
    q[2]   = qz;
    proj   = 0;
    sum_sq = '0;
    over   = 1'b0;
    for (c = 0; c < 3; c++) begin
      offs[c] = longint'($signed(q[c])) - longint'(seg_start[c]);
      dirc[c] = longint'(seg_dir[c]);
      proj    = proj + offs[c] * dirc[c];
    end
    // Projection back to Q16.16 rounds towards minus infinity, then clamps.
    proj = proj >>> DIR_FRAC;
    if (proj < 0) proj = 0;
    if (proj > longint'(seg_len)) proj = longint'(seg_len);
    for (c = 0; c < 3; c++) begin
      resid = proj * dirc[c] - (offs[c] <<< DIR_FRAC);
      resid = (resid + ROUND_HALF) >>> DIR_FRAC;
      mag   = (resid < 0) ? 64'(-resid) : 64'(resid);
      if (mag > 64'hFFFF_FFFF) begin
        over = 1'b1;
      end else begin
        sq     = ACC_W'(mag[31:0]) * ACC_W'(mag[31:0]);
        sum_sq = sum_sq + (ACC_W+2)'(sq);
      end
    end
    if (|sum_sq[ACC_W+1:ACC_W]) over = 1'b1;
    res.saturated = over;
    res.distance  = over ? '1 : floor_sqrt(sum_sq[ACC_W-1:0]);
    return res;
  endfunction

  always @(posedge clk) begin
    dist_result_t got;
    dist_result_t want;
    if (rst) begin
      seg_start[0] = '0;
      seg_start[1] = '0;
      seg_start[2] = '0;
      seg_dir[0]   = DIR_X_RESET;
      seg_dir[1]   = '0;
      seg_dir[2]   = '0;
      seg_len      = '0;
      expected_dist_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X: seg_start[0] = cfg_data[FIELD_W-1:0];
          REG_START_Y: seg_start[1] = cfg_data[FIELD_W-1:0];
          REG_START_Z: seg_start[2] = cfg_data[FIELD_W-1:0];
          REG_DIR_X:   seg_dir[0]   = cfg_data[DIR_W-1:0];
          REG_DIR_Y:   seg_dir[1]   = cfg_data[DIR_W-1:0];
          REG_DIR_Z:   seg_dir[2]   = cfg_data[DIR_W-1:0];
          REG_SEG_LEN: seg_len      = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_dist_q.push_back(predict_distance(query_x, query_y, query_z));
      if (out_valid && out_ready) begin
        got.distance  = distance;
        got.saturated = saturated;
        if (expected_dist_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("checker: result with no request outstanding: distance=%h saturated=%b",
                     got.distance, got.saturated);
        end else begin
          want = expected_dist_q.pop_front();
          checked++;
          if (want.saturated) saturations++;
          if (got.distance !== want.distance || got.saturated !== want.saturated) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("checker: mismatch on result %0d: expected %h/%b, got %h/%b",
                       checked, want.distance, want.saturated, got.distance, got.saturated);
          end
        end
      end
    end
    pending = expected_dist_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the segment point distance unit
// Programs a series of segments, drives directed and random query requests
// with random gaps and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import spd_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 8;
  localparam int IDLE_PERCENT    = 24;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 60;
  localparam int CYCLE_LIMIT     = 200000;

  // The write port has one index beyond the last register; writes to it must
  // leave every register untouched.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [FIELD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic        [LEN_W-1:0]   LEN_MAX   = 31'h7FFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [FIELD_W-1:0]   query_x;
  logic [FIELD_W-1:0]   query_y;
  logic [FIELD_W-1:0]   query_z;
  logic                 out_valid;
  logic                 out_ready;
  logic [DIST_W-1:0]    distance;
  logic                 saturated;

  int fail_count;
  int pending;
  int checked;
  int saturations;
  int cycle_count;
  int settings_used;

  // Shared with the receiver process: calm switches idling off on both sides,
  // hold_request asks the receiver for one long stretch with ready low.
  logic calm;
  logic hold_request;

  // Stimulus-side copy of the geometry, used only to aim queries at the
  // segment; the checker keeps its own copy from the write port.
  logic signed [FIELD_W-1:0] seg_start [3];
  logic signed [DIR_W-1:0]   seg_dir   [3];
  logic        [LEN_W-1:0]   seg_len;

  segment_point_distance_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .query_x   (query_x),
    .query_y   (query_y),
    .query_z   (query_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance),
    .saturated (saturated)
  );

  spd_distance_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .query_x     (query_x),
    .query_y     (query_y),
    .query_z     (query_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance    (distance),
    .saturated   (saturated),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .saturations (saturations)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: run stopped by the watchdog after %0d cycles", cycle_count);
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver. Ready changes only at the falling edge. A hold request keeps
  // ready low for a long stretch so that the pipeline and its output buffer
  // fill up and the unit has to refuse further query requests.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready    = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // One query request. Idle cycles come before the request is raised, so a
  // valid that is already high is never dropped and raised in the same step.
  task automatic send_query(input logic [FIELD_W-1:0] qx, input logic [FIELD_W-1:0] qy,
                            input logic [FIELD_W-1:0] qz);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    query_x  = qx;
    query_y  = qy;
    query_z  = qz;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Reprogramming is only safe once every result of the previous setting has
  // come back and a settle delay has let the pipeline empty.
  task automatic program_segment(input logic signed [FIELD_W-1:0] sx,
                                 input logic signed [FIELD_W-1:0] sy,
                                 input logic signed [FIELD_W-1:0] sz,
                                 input logic signed [DIR_W-1:0]   dx,
                                 input logic signed [DIR_W-1:0]   dy,
                                 input logic signed [DIR_W-1:0]   dz,
                                 input logic        [LEN_W-1:0]   len);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    seg_start[0] = sx;
    seg_start[1] = sy;
    seg_start[2] = sz;
    seg_dir[0]   = dx;
    seg_dir[1]   = dy;
    seg_dir[2]   = dz;
    seg_len      = len;
    write_reg(REG_START_X, CFG_W'(sx));
    write_reg(REG_START_Y, CFG_W'(sy));
    write_reg(REG_START_Z, CFG_W'(sz));
    write_reg(REG_DIR_X, CFG_W'(dx));
    write_reg(REG_DIR_Y, CFG_W'(dy));
    write_reg(REG_DIR_Z, CFG_W'(dz));
    write_reg(REG_SEG_LEN, CFG_W'(len));
    settings_used++;
  endtask

  // A random segment: unit directions along axes and diagonals, or arbitrary
  // components that need not have unit length; short, zero or huge lengths.
  task automatic random_segment();
    logic signed [FIELD_W-1:0] s [3];
    logic signed [DIR_W-1:0]   d [3];
    logic        [LEN_W-1:0]   len;
    int c;
    for (c = 0; c < 3; c++) begin
      if ($urandom_range(3) == 0) s[c] = $urandom;
      else s[c] = $signed($urandom) >>> 8;
      d[c] = '0;
    end
    case ($urandom_range(4))
      0: d[$urandom_range(2)] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      1: begin
        d[0] = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
        d[1] = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
      end
      2: begin
        for (c = 0; c < 3; c++) d[c] = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
      end
      default: begin
        for (c = 0; c < 3; c++) d[c] = DIR_W'(int'($urandom_range(32768)) - 16384);
      end
    endcase
    case ($urandom_range(3))
      0:       len = '0;
      1:       len = LEN_W'($urandom);
      default: len = LEN_W'($urandom_range(32'h0400_0000));
    endcase
    program_segment(s[0], s[1], s[2], d[0], d[1], d[2], len);
  endtask

  // Most random queries fall near the segment, somewhere from a little before
  // its start to a little past its end; the rest are raw 32-bit noise or
  // picks from the coordinate extremes.
  task automatic random_query();
    logic [FIELD_W-1:0] q [3];
    longint tt;
    longint pos;
    int mode;
    int c;
    mode = $urandom_range(99);
    tt   = (longint'(seg_len) * longint'($urandom_range(150))) / 100 - longint'(seg_len) / 4;
    for (c = 0; c < 3; c++) begin
      if (mode < 60) begin
        pos  = longint'(seg_start[c]) + ((tt * longint'(seg_dir[c])) >>> DIR_FRAC)
             + (longint'($signed($urandom)) >>> $urandom_range(31, 8));
        q[c] = pos[FIELD_W-1:0];
      end else if (mode < 85) begin
        q[c] = $urandom;
      end else begin
        case ($urandom_range(5))
          0:       q[c] = COORD_MAX;
          1:       q[c] = COORD_MIN;
          2:       q[c] = '0;
          3:       q[c] = '1;
          4:       q[c] = 32'd1;
          default: q[c] = seg_start[c];
        endcase
      end
    end
    send_query(q[0], q[1], q[2]);
  endtask

  initial begin
    int ph;
    int n;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_START_X;
    cfg_data      = '0;
    in_valid      = 1'b0;
    query_x       = '0;
    query_y       = '0;
    query_z       = '0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    settings_used = 1;
    seg_start[0]  = '0;
    seg_start[1]  = '0;
    seg_start[2]  = '0;
    seg_dir[0]    = DIR_X_RESET;
    seg_dir[1]    = '0;
    seg_dir[2]    = '0;
    seg_len       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset geometry: zero length at the origin, so the distance is just the
    // norm of the query point. The extreme corners come close to the top of the
    // output range without saturating.
    send_query('0, '0, '0);
    send_query(32'h0001_0000, '0, '0);
    send_query('1, '1, '1);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(COORD_MIN, COORD_MIN, COORD_MIN);
    send_query(COORD_MAX, COORD_MIN, '0);

    // A ten-unit segment along x from (1.5, -2, 3): points before the start,
    // past the end, beside the segment and off it on two axes.
    program_segment(32'sh0001_8000, -32'sh0002_0000, 32'sh0003_0000,
                    16'sd16384, 16'sd0, 16'sd0, 31'h000A_0000);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    send_query('0, -32'sh0002_0000, 32'sh0003_0000);
    send_query(32'sh0014_0000, -32'sh0002_0000, 32'sh0003_0000);
    send_query(32'sh0005_0000, -32'sh0002_0000, 32'sh0007_0000);
    send_query(32'sh0005_0000, 32'sh0001_0000, 32'sh0007_0000);

    // Extremes: start at opposite corners, a direction of length root three
    // and the longest segment. The first query makes one residual component
    // too large for the output on its own; the others do not saturate.
    program_segment(COORD_MAX, COORD_MIN, COORD_MIN,
                    16'sd16384, 16'sd16384, 16'sd16384, LEN_MAX);
    send_query(COORD_MIN, COORD_MAX, COORD_MAX);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(COORD_MIN, COORD_MIN, COORD_MIN);
    send_query('0, '0, '0);

    // Negative unit direction along z from the origin.
    program_segment('0, '0, '0, 16'sd0, 16'sd0, -16'sd16384, LEN_MAX);
    send_query('0, '0, -32'sh0005_0000);
    send_query(32'sh0003_0000, 32'sh0004_0000, -32'sh0064_0000);
    send_query('0, '0, 32'sh000A_0000);

    // A zero direction: the projection is always zero and the segment
    // degenerates to its start point.
    program_segment(-32'sh0007_0000, '0, 32'sh0002_0000, 16'sd0, 16'sd0, 16'sd0,
                    31'h03E8_0000);
    send_query(-32'sh0007_0000, '0, 32'sh0002_0000);
    send_query(COORD_MAX, '0, '0);

    // Random part. The second phase also asks the receiver for a long hold
    // while requests keep coming; the fourth runs at full rate on both sides.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_segment();
      calm = (ph == 3);
      if (ph == 1) hold_request = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_query();
      calm = 1'b0;
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench: %0d distance results checked over %0d segment settings, %0d saturated.",
             checked, settings_used, saturations);
    $write("testbench: covered extremes, non-unit and zero directions, an ignored register");
    $display(" index, a %0d-cycle output hold and a full-rate stretch.", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
